// ----- src/bsa_pkg.sv -----
`timescale 1ns / 1ps

package bsa_pkg;

   // Default sizing of the tables
   localparam int DEF_MAX_PROCESSES = 8;
   localparam int DEF_MAX_RESOURCES = 4;
   localparam int DEF_COUNT_WIDTH   = 16;

   // Channel field widths
   localparam int COMMAND_W  = 2;
   localparam int PROCESS_W  = 3;
   localparam int RESOURCE_W = 2;
   localparam int AMOUNT_W   = 16;
   localparam int STATUS_W   = 3;
   localparam int MASK_W     = 8;

   // Register port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;
   localparam int NUM_RES_W   = 3;
   localparam int NUM_PROC_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_RESOURCES = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_PROCESSES = 1'd1;

   localparam logic [NUM_RES_W-1:0]  NUM_RES_RESET  = 3'd4;
   localparam logic [NUM_PROC_W-1:0] NUM_PROC_RESET = 4'd8;

   // Command codes
   localparam logic [COMMAND_W-1:0] CMD_SET_AVAIL = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_SET_CLAIM = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_REQUEST   = 2'd2;
   localparam logic [COMMAND_W-1:0] CMD_RESERVED  = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNSAFE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVER    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD     = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;       // capture the accepted item
      logic exec;        // decode the item, update tables
      logic safe_init;   // load work vector, clear finish flags
      logic pass_start;  // clear the per-pass progress flag
      logic scan_rd;     // read the rows of the scan index
      logic verdict;     // settle grant or roll back
      logic load_rsp;    // move the result into the output register
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic start_check; // request applied, safety check needed
      logic progress;    // some process finished in this pass
      logic all_done;    // every process in use has finished
   } dp_status_type;

endpackage

// ----- src/bsa_if.sv -----
`timescale 1ns / 1ps

interface bsa_req_if;
   logic                              valid;
   logic                              ready;
   logic [bsa_pkg::COMMAND_W-1:0]     command;
   logic [bsa_pkg::PROCESS_W-1:0]     process;
   logic [bsa_pkg::RESOURCE_W-1:0]    resource;
   logic [bsa_pkg::AMOUNT_W-1:0]      amount;
   logic                              last;

   modport source (output valid, command, process, resource, amount, last, input ready);
   modport sink (input valid, command, process, resource, amount, last, output ready);
endinterface

interface bsa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bsa_pkg::STATUS_W-1:0]   status;
   logic [bsa_pkg::MASK_W-1:0]     finished_mask;

   modport source (output valid, status, finished_mask, input ready);
   modport sink (input valid, status, finished_mask, output ready);
endinterface

interface bsa_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bsa_pkg::CSR_INDEX_W-1:0]  index;
   logic [bsa_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/banker_safety_allocator.sv -----
`timescale 1ns / 1ps

// Banker's-algorithm allocator with a safety check on every request.
// Channels: req_ch takes one command per transfer (set available count,
// set maximum claim, or one request element; the element marked last
// applies the pending request and runs the safety check). rsp_ch returns
// one result per item: status and the mask of processes that could finish.
// csr_ch writes the resource and process counts in use; it is always ready.
// Steps: capture the item, read its table row, decode and update tables,
// then move the result into the output register. An applied final request
// element adds a safety check before the result: load the work vector,
// then each pass reads one process row per cycle from the
// claim/allocation/need tables and compares all resources in parallel;
// passes repeat while one makes progress, at most the number of processes;
// last the grant is settled or rolled back. One item is in work at a time;
// the next is taken once its result sits in the output register.
// Reset clears available counts, pending elements and row flags at once
// (table rows read as zero) and sets 4 resources and 8 processes in use.
// When the receiver stalls, the result holds in the output register; the
// next item is accepted and worked, then waits until that register frees.
module banker_safety_allocator #(
   parameter int MAX_PROCESSES = bsa_pkg::DEF_MAX_PROCESSES,
   parameter int MAX_RESOURCES = bsa_pkg::DEF_MAX_RESOURCES,
   parameter int COUNT_WIDTH   = bsa_pkg::DEF_COUNT_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   bsa_req_if.sink   req_ch,
   bsa_rsp_if.source rsp_ch,
   bsa_csr_if.sink   csr_ch
);
   import bsa_pkg::*;

   localparam int NRW = $clog2(MAX_RESOURCES + 1);
   localparam int NPW = $clog2(MAX_PROCESSES + 1);
   localparam int PIW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;

   logic [NRW-1:0] nr;
   logic [NPW-1:0] np;
   ctrl_cmd_type   cmd;
   dp_status_type  status;
   logic [PIW-1:0] scan_idx;

   bsa_csr #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .MAX_RESOURCES (MAX_RESOURCES),
      .NRW           (NRW),
      .NPW           (NPW)
   ) u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .nr     (nr),
      .np     (np)
   );

   bsa_ctrl #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .NPW           (NPW),
      .PIW           (PIW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .np        (np),
      .status    (status),
      .cmd       (cmd),
      .scan_idx  (scan_idx)
   );

   bsa_dpath #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .MAX_RESOURCES (MAX_RESOURCES),
      .COUNT_WIDTH   (COUNT_WIDTH),
      .NRW           (NRW),
      .NPW           (NPW),
      .PIW           (PIW)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .scan_idx    (scan_idx),
      .nr          (nr),
      .np          (np),
      .in_command  (req_ch.command),
      .in_process  (req_ch.process),
      .in_resource (req_ch.resource),
      .in_amount   (req_ch.amount),
      .in_last     (req_ch.last),
      .status      (status),
      .rsp_status  (rsp_ch.status),
      .rsp_mask    (rsp_ch.finished_mask)
   );

endmodule

// ----- src/bsa_csr.sv -----
`timescale 1ns / 1ps

module bsa_csr #(
   parameter int MAX_PROCESSES = bsa_pkg::DEF_MAX_PROCESSES,
   parameter int MAX_RESOURCES = bsa_pkg::DEF_MAX_RESOURCES,
   parameter int NRW = $clog2(MAX_RESOURCES + 1),
   parameter int NPW = $clog2(MAX_PROCESSES + 1)
) (
   input  logic           clock,
   input  logic           reset,
   bsa_csr_if.sink        csr_ch,
   output logic [NRW-1:0] nr,
   output logic [NPW-1:0] np
);
   import bsa_pkg::*;

   logic [NUM_RES_W-1:0]  num_res_ff;
   logic [NUM_PROC_W-1:0] num_proc_ff;

   // Accept every write at once
   assign csr_ch.ready = 1'b1;

   // Store the register written by a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         num_res_ff  <= NUM_RES_RESET;
         num_proc_ff <= NUM_PROC_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_NUM_RESOURCES: num_res_ff  <= csr_ch.data[NUM_RES_W-1:0];
            CSR_NUM_PROCESSES: num_proc_ff <= csr_ch.data[NUM_PROC_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp counts in use to one through the table size
   always_comb begin
      if (num_res_ff == '0) begin
         nr = NRW'(1);
      end else if (32'(num_res_ff) > MAX_RESOURCES) begin
         nr = NRW'(MAX_RESOURCES);
      end else begin
         nr = NRW'(num_res_ff);
      end
      if (num_proc_ff == '0) begin
         np = NPW'(1);
      end else if (32'(num_proc_ff) > MAX_PROCESSES) begin
         np = NPW'(MAX_PROCESSES);
      end else begin
         np = NPW'(num_proc_ff);
      end
   end

endmodule

// ----- src/bsa_ctrl.sv -----
`timescale 1ns / 1ps

module bsa_ctrl #(
   parameter int MAX_PROCESSES = bsa_pkg::DEF_MAX_PROCESSES,
   parameter int NPW = $clog2(MAX_PROCESSES + 1),
   parameter int PIW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [NPW-1:0]         np,
   input  bsa_pkg::dp_status_type status,
   output bsa_pkg::ctrl_cmd_type  cmd,
   output logic [PIW-1:0]         scan_idx
);
   import bsa_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_READ      = 8'b0000_0010,
      S_EXEC      = 8'b0000_0100,
      S_SAFE_INIT = 8'b0000_1000,
      S_SCAN      = 8'b0001_0000,
      S_PASS_END  = 8'b0010_0000,
      S_VERDICT   = 8'b0100_0000,
      S_DONE      = 8'b1000_0000
   } state_type;

   state_type      state_ff, state_in;
   logic [PIW-1:0] idx_ff, idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           last_idx;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign scan_idx  = idx_ff;
   assign last_idx  = (32'(idx_ff) == 32'(np) - 32'd1);

   // Sequence one item through decode, safety passes and result
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.start_check ? S_SAFE_INIT : S_DONE;
         end
         S_SAFE_INIT: begin
            cmd.safe_init  = 1'b1;
            cmd.pass_start = 1'b1;
            idx_in         = '0;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (last_idx) begin
               state_in = S_PASS_END;
            end else begin
               idx_in = idx_ff + PIW'(1);
            end
         end
         S_PASS_END: begin
            if (status.progress && !status.all_done) begin
               cmd.pass_start = 1'b1;
               idx_in         = '0;
               state_in       = S_SCAN;
            end else begin
               state_in = S_VERDICT;
            end
         end
         S_VERDICT: begin
            cmd.verdict = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result valid until the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // One item at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted during work");

   // Scan index stays within processes in use
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (32'(idx_ff) < 32'(np)))
      else $error("scan index beyond processes in use");

endmodule

// ----- src/bsa_dpath.sv -----
`timescale 1ns / 1ps

module bsa_dpath #(
   parameter int MAX_PROCESSES = bsa_pkg::DEF_MAX_PROCESSES,
   parameter int MAX_RESOURCES = bsa_pkg::DEF_MAX_RESOURCES,
   parameter int COUNT_WIDTH   = bsa_pkg::DEF_COUNT_WIDTH,
   parameter int NRW = $clog2(MAX_RESOURCES + 1),
   parameter int NPW = $clog2(MAX_PROCESSES + 1),
   parameter int PIW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bsa_pkg::ctrl_cmd_type             cmd,
   input  logic [PIW-1:0]                    scan_idx,
   input  logic [NRW-1:0]                    nr,
   input  logic [NPW-1:0]                    np,
   input  logic [bsa_pkg::COMMAND_W-1:0]     in_command,
   input  logic [bsa_pkg::PROCESS_W-1:0]     in_process,
   input  logic [bsa_pkg::RESOURCE_W-1:0]    in_resource,
   input  logic [bsa_pkg::AMOUNT_W-1:0]      in_amount,
   input  logic                              in_last,
   output bsa_pkg::dp_status_type            status,
   output logic [bsa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bsa_pkg::MASK_W-1:0]        rsp_mask
);
   import bsa_pkg::*;

   localparam int RIW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int WW  = COUNT_WIDTH + $clog2(MAX_PROCESSES + 1);

   typedef logic [MAX_RESOURCES-1:0][COUNT_WIDTH-1:0] row_type;
   typedef logic [MAX_RESOURCES-1:0][WW-1:0]          work_type;

   // Claim, allocation and need tables, one row per process
   row_type max_mem   [MAX_PROCESSES];
   row_type alloc_mem [MAX_PROCESSES];
   row_type need_mem  [MAX_PROCESSES];
   logic [MAX_PROCESSES-1:0] row_valid_ff;

   // Registered read port
   row_type        max_rd_ff, alloc_rd_ff, need_rd_ff;
   logic           valid_rd_ff;
   logic [PIW-1:0] idx_rd_ff;
   logic           scan_rd_ff;

   // Captured item
   logic [COMMAND_W-1:0]   cmd_ff;
   logic [PROCESS_W-1:0]   p_ff;
   logic [RESOURCE_W-1:0]  r_ff;
   logic [COUNT_WIDTH-1:0] amt_ff;
   logic                   last_ff;

   // Per-resource lanes
   row_type  avail_ff, pending_ff, hold_avail_ff;
   row_type  hold_max_ff, hold_alloc_ff, hold_need_ff;
   work_type work_ff;
   logic [MAX_PROCESSES-1:0] finish_ff;
   logic                     progress_ff;
   logic [STATUS_W-1:0]      res_status_ff, rsp_status_ff;
   logic [MASK_W-1:0]        res_mask_ff, rsp_mask_ff;

   logic [PIW-1:0]         p_row, rd_row;
   logic [RIW-1:0]         r_idx;
   logic [MAX_RESOURCES-1:0] lane_on;
   logic [MAX_PROCESSES-1:0] proc_on;
   row_type                max_e, alloc_e, need_e, pm;
   row_type                wr_max, wr_alloc, wr_need, avail_in, pending_in;
   logic                   bad, req_ok, ex_wr, mem_we, start_check;
   logic [STATUS_W-1:0]    ex_status;
   logic                   fits, hit, safe_all;
   logic [MAX_PROCESSES-1:0] finish_set;
   work_type               work_in;

   assign p_row  = PIW'(p_ff);
   assign r_idx  = RIW'(r_ff);
   assign rd_row = cmd.scan_rd ? scan_idx : p_row;
   assign max_e   = valid_rd_ff ? max_rd_ff : '0;
   assign alloc_e = valid_rd_ff ? alloc_rd_ff : '0;
   assign need_e  = valid_rd_ff ? need_rd_ff : '0;

   // Mark lanes and processes in use
   always_comb begin
      for (int k = 0; k < MAX_RESOURCES; k++) begin
         lane_on[k] = (k < 32'(nr));
      end
      for (int p = 0; p < MAX_PROCESSES; p++) begin
         proc_on[p] = (p < 32'(np));
      end
   end

   // Decode the item and work out table updates
   always_comb begin
      bad = (cmd_ff == CMD_RESERVED) || (32'(r_ff) >= 32'(nr)) ||
            ((cmd_ff != CMD_SET_AVAIL) && (32'(p_ff) >= 32'(np)));
      for (int k = 0; k < MAX_RESOURCES; k++) begin
         pm[k] = (k == 32'(r_ff)) ? amt_ff : pending_ff[k];
      end
      req_ok = 1'b1;
      for (int k = 0; k < MAX_RESOURCES; k++) begin
         if (lane_on[k] && ((pm[k] > need_e[k]) || (pm[k] > avail_ff[k]))) begin
            req_ok = 1'b0;
         end
      end
      ex_status   = ST_STORED;
      ex_wr       = 1'b0;
      start_check = 1'b0;
      wr_max      = max_e;
      wr_alloc    = alloc_e;
      wr_need     = need_e;
      avail_in    = avail_ff;
      pending_in  = pending_ff;
      if (bad) begin
         ex_status = ST_BAD;
      end else begin
         unique case (cmd_ff)
            CMD_SET_AVAIL: begin
               avail_in[r_idx] = amt_ff;
            end
            CMD_SET_CLAIM: begin
               if (amt_ff > avail_ff[r_idx]) begin
                  ex_status = ST_OVER;
               end else begin
                  ex_wr          = 1'b1;
                  wr_max[r_idx]  = amt_ff;
                  wr_need[r_idx] = (amt_ff >= alloc_e[r_idx]) ?
                                   amt_ff - alloc_e[r_idx] : '0;
               end
            end
            CMD_REQUEST: begin
               if (amt_ff > max_e[r_idx]) begin
                  ex_status = ST_OVER;
                  if (last_ff) begin
                     pending_in = '0;
                  end
               end else if (!last_ff) begin
                  pending_in[r_idx] = amt_ff;
               end else begin
                  pending_in = '0;
                  if (!req_ok) begin
                     ex_status = ST_OVER;
                  end else begin
                     ex_wr       = 1'b1;
                     start_check = 1'b1;
                     for (int k = 0; k < MAX_RESOURCES; k++) begin
                        if (lane_on[k]) begin
                           wr_alloc[k] = alloc_e[k] + pm[k];
                           wr_need[k]  = need_e[k] - pm[k];
                           avail_in[k] = avail_ff[k] - pm[k];
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Evaluate one process of the safety scan
   always_comb begin
      fits = 1'b1;
      for (int k = 0; k < MAX_RESOURCES; k++) begin
         if (lane_on[k] && (WW'(need_e[k]) > work_ff[k])) begin
            fits = 1'b0;
         end
      end
      hit = scan_rd_ff && !finish_ff[idx_rd_ff] && fits;
      work_in = work_ff;
      for (int k = 0; k < MAX_RESOURCES; k++) begin
         if (lane_on[k]) begin
            work_in[k] = work_ff[k] + WW'(alloc_e[k]);
         end
      end
      finish_set = finish_ff;
      if (hit) begin
         finish_set[idx_rd_ff] = 1'b1;
      end
      safe_all = ((finish_ff & proc_on) == proc_on);
   end

   assign status.start_check = start_check;
   assign status.progress    = progress_ff | hit;
   assign status.all_done    = ((finish_set & proc_on) == proc_on);

   assign mem_we = (cmd.exec && ex_wr) || (cmd.verdict && !safe_all);

   // Table memories: one row written, one row read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         if (cmd.verdict) begin
            max_mem[p_row]   <= hold_max_ff;
            alloc_mem[p_row] <= hold_alloc_ff;
            need_mem[p_row]  <= hold_need_ff;
         end else begin
            max_mem[p_row]   <= wr_max;
            alloc_mem[p_row] <= wr_alloc;
            need_mem[p_row]  <= wr_need;
         end
      end
      max_rd_ff   <= max_mem[rd_row];
      alloc_rd_ff <= alloc_mem[rd_row];
      need_rd_ff  <= need_mem[rd_row];
      valid_rd_ff <= row_valid_ff[rd_row];
      idx_rd_ff   <= rd_row;
   end

   // Control and table state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         avail_ff     <= '0;
         pending_ff   <= '0;
         finish_ff    <= '0;
         progress_ff  <= 1'b0;
         scan_rd_ff   <= 1'b0;
      end else begin
         scan_rd_ff <= cmd.scan_rd;
         if (mem_we) begin
            row_valid_ff[p_row] <= 1'b1;
         end
         if (cmd.exec) begin
            avail_ff   <= avail_in;
            pending_ff <= pending_in;
         end
         if (cmd.verdict && !safe_all) begin
            avail_ff <= hold_avail_ff;
         end
         if (cmd.safe_init) begin
            finish_ff <= '0;
         end else begin
            finish_ff <= finish_set;
         end
         if (cmd.pass_start) begin
            progress_ff <= 1'b0;
         end else if (hit) begin
            progress_ff <= 1'b1;
         end
      end
   end

   // Item capture, work vector, rollback copies and results
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff  <= in_command;
         p_ff    <= in_process;
         r_ff    <= in_resource;
         amt_ff  <= COUNT_WIDTH'(in_amount);
         last_ff <= in_last;
      end
      if (cmd.exec) begin
         hold_avail_ff <= avail_ff;
         hold_max_ff   <= max_e;
         hold_alloc_ff <= alloc_e;
         hold_need_ff  <= need_e;
         res_status_ff <= ex_status;
         res_mask_ff   <= '0;
      end
      if (cmd.safe_init) begin
         for (int k = 0; k < MAX_RESOURCES; k++) begin
            work_ff[k] <= WW'(avail_ff[k]);
         end
      end else if (hit) begin
         work_ff <= work_in;
      end
      if (cmd.verdict) begin
         res_status_ff <= safe_all ? ST_GRANTED : ST_UNSAFE;
         res_mask_ff   <= MASK_W'(finish_ff & proc_on);
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_mask_ff   <= res_mask_ff;
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_mask   = rsp_mask_ff;

   // A well-formed final request element always empties the pending vector
   a_pending_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !bad && (cmd_ff == CMD_REQUEST) && last_ff) |=> (pending_ff == '0))
      else $error("pending request not cleared");

   // Rollback restores the available counts
   a_rollback_avail: assert property (@(posedge clock) disable iff (reset)
      (cmd.verdict && !safe_all) |=> (avail_ff == $past(hold_avail_ff)))
      else $error("available counts not restored on rollback");

   // Scan evaluation only touches processes in use
   a_eval_range: assert property (@(posedge clock) disable iff (reset)
      scan_rd_ff |-> (32'(idx_rd_ff) < 32'(np)))
      else $error("scan evaluated a process not in use");

endmodule

// ----- tb/banker_safety_allocator_tb.sv -----
`timescale 1ns / 1ps

module banker_safety_allocator_tb;
   import bsa_pkg::*;

   localparam int PROC_SLOTS      = DEF_MAX_PROCESSES;
   localparam int RES_SLOTS       = DEF_MAX_RESOURCES;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 100;
   localparam int ITEMS_PER_PHASE = 135;
   localparam int NUM_PHASES      = 7;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [COMMAND_W-1:0]  command;
      logic [PROCESS_W-1:0]  proc_id;
      logic [RESOURCE_W-1:0] resource;
      logic [AMOUNT_W-1:0]   amount;
      logic                  last;
   } alloc_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [MASK_W-1:0]   finished_mask;
   } alloc_result_type;

   typedef struct packed {
      logic [COMMAND_W-1:0]  command;
      logic [PROCESS_W-1:0]  proc_id;
      logic [RESOURCE_W-1:0] resource;
      logic [AMOUNT_W-1:0]   amount;
      logic                  last;
      logic                  fixed;
      logic [STATUS_W-1:0]   status;
      logic [MASK_W-1:0]     finished_mask;
   } directed_row_type;

   // Directed sequence, run with the reset counts (4 resources, 8 processes).
   // Rows with fixed set carry a hand-written result; the rest use the predictor.
   localparam directed_row_type DIRECTED_ROWS [25] = '{
      '{CMD_RESERVED,  3'd0, 2'd0, 16'd0,     1'b0, 1'b1, ST_BAD,    8'h00},
      '{CMD_RESERVED,  3'd7, 2'd3, 16'd65535, 1'b1, 1'b1, ST_BAD,    8'h00},
      '{CMD_SET_CLAIM, 3'd0, 2'd0, 16'd1,     1'b0, 1'b1, ST_OVER,   8'h00},
      '{CMD_SET_AVAIL, 3'd0, 2'd0, 16'd65535, 1'b0, 1'b1, ST_STORED, 8'h00},
      '{CMD_SET_AVAIL, 3'd5, 2'd1, 16'd65535, 1'b1, 1'b1, ST_STORED, 8'h00},
      '{CMD_SET_AVAIL, 3'd0, 2'd2, 16'd100,   1'b0, 1'b1, ST_STORED, 8'h00},
      '{CMD_SET_AVAIL, 3'd0, 2'd3, 16'd0,     1'b0, 1'b1, ST_STORED, 8'h00},
      '{CMD_SET_CLAIM, 3'd7, 2'd0, 16'd65535, 1'b0, 1'b1, ST_STORED, 8'h00},
      '{CMD_SET_CLAIM, 3'd7, 2'd1, 16'd10,    1'b0, 1'b1, ST_STORED, 8'h00},
      '{CMD_SET_CLAIM, 3'd0, 2'd2, 16'd100,   1'b0, 1'b1, ST_STORED, 8'h00},
      '{CMD_SET_CLAIM, 3'd1, 2'd2, 16'd100,   1'b0, 1'b1, ST_STORED, 8'h00},
      // element above the claim is dropped, pending kept
      '{CMD_REQUEST,   3'd7, 2'd1, 16'd11,    1'b0, 1'b1, ST_OVER,   8'h00},
      '{CMD_REQUEST,   3'd7, 2'd0, 16'd65535, 1'b0, 1'b1, ST_STORED, 8'h00},
      '{CMD_REQUEST,   3'd7, 2'd1, 16'd10,    1'b0, 1'b1, ST_STORED, 8'h00},
      // replaces the pending entry for resource 1, then grants
      '{CMD_REQUEST,   3'd7, 2'd1, 16'd5,     1'b1, 1'b0, ST_STORED, 8'h00},
      '{CMD_REQUEST,   3'd0, 2'd2, 16'd60,    1'b1, 1'b0, ST_STORED, 8'h00},
      // above available, then an unsafe request that rolls back
      '{CMD_REQUEST,   3'd1, 2'd2, 16'd50,    1'b1, 1'b0, ST_STORED, 8'h00},
      '{CMD_REQUEST,   3'd1, 2'd2, 16'd30,    1'b1, 1'b0, ST_STORED, 8'h00},
      // above need
      '{CMD_REQUEST,   3'd0, 2'd2, 16'd41,    1'b1, 1'b0, ST_STORED, 8'h00},
      // over-claim element marked last discards the pending request
      '{CMD_REQUEST,   3'd0, 2'd2, 16'd10,    1'b0, 1'b0, ST_STORED, 8'h00},
      '{CMD_REQUEST,   3'd0, 2'd2, 16'd101,   1'b1, 1'b0, ST_STORED, 8'h00},
      '{CMD_REQUEST,   3'd0, 2'd0, 16'd0,     1'b1, 1'b0, ST_STORED, 8'h00},
      // pending from one process lands on the process of the last element
      '{CMD_REQUEST,   3'd1, 2'd2, 16'd20,    1'b0, 1'b0, ST_STORED, 8'h00},
      '{CMD_REQUEST,   3'd0, 2'd3, 16'd0,     1'b1, 1'b0, ST_STORED, 8'h00},
      // claim below the held count leaves need at zero
      '{CMD_SET_CLAIM, 3'd7, 2'd0, 16'd0,     1'b0, 1'b0, ST_STORED, 8'h00}
   };

   // Register settings per random phase, extremes and clamped values among them
   localparam logic [CSR_DATA_W-1:0] RES_SETTINGS [NUM_PHASES] =
      '{4'd4, 4'd1, 4'd0, 4'd15, 4'd2, 4'd13, 4'd3};
   localparam logic [CSR_DATA_W-1:0] PROC_SETTINGS [NUM_PHASES] =
      '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd5, 4'd8};

   logic clock = 1'b0;
   logic reset;

   bsa_req_if req_bus ();
   bsa_rsp_if rsp_bus ();
   bsa_csr_if csr_bus ();

   banker_safety_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always #4 clock = ~clock;

   // Allocator state as the block should hold it
   logic [31:0]           avail_units   [RES_SLOTS];
   logic [31:0]           claim_units   [PROC_SLOTS][RES_SLOTS];
   logic [31:0]           held_units    [PROC_SLOTS][RES_SLOTS];
   logic [31:0]           need_units    [PROC_SLOTS][RES_SLOTS];
   logic [31:0]           pending_units [RES_SLOTS];
   logic [NUM_RES_W-1:0]  res_in_use;
   logic [NUM_PROC_W-1:0] proc_in_use;

   alloc_result_type awaited_results [$];
   int               mismatches   = 0;
   int               items_sent   = 0;
   int               quiet_cycles = 0;
   int               pace_count   = 0;
   int               idle_pct     = 10;
   bit               idle_on      = 1'b1;

   function automatic int res_limit();
      if (res_in_use == 0) return 1;
      if (res_in_use > RES_SLOTS) return RES_SLOTS;
      return res_in_use;
   endfunction

   function automatic int proc_limit();
      if (proc_in_use == 0) return 1;
      if (proc_in_use > PROC_SLOTS) return PROC_SLOTS;
      return proc_in_use;
   endfunction

   // Apply one item to the allocator state and return the result it causes
   function automatic alloc_result_type allocator_outcome(alloc_item_type it);
      int                    nr, np, p, r, k, q, sweep;
      logic                  fits_all, fits, progress;
      logic [31:0]           work_units [RES_SLOTS];
      logic [PROC_SLOTS-1:0] done;
      alloc_result_type      res;
      nr = res_limit();
      np = proc_limit();
      p = it.proc_id;
      r = it.resource;
      res.status = ST_STORED;
      res.finished_mask = '0;
      if (it.command == CMD_RESERVED || r >= nr || (it.command != CMD_SET_AVAIL && p >= np)) begin
         res.status = ST_BAD;
      end else if (it.command == CMD_SET_AVAIL) begin
         avail_units[r] = it.amount;
      end else if (it.command == CMD_SET_CLAIM) begin
         if (it.amount > avail_units[r]) begin
            res.status = ST_OVER;
         end else begin
            claim_units[p][r] = it.amount;
            need_units[p][r] = (it.amount >= held_units[p][r]) ? it.amount - held_units[p][r] : 0;
         end
      end else if (it.amount > claim_units[p][r]) begin
         res.status = ST_OVER;
         if (it.last) begin
            for (k = 0; k < RES_SLOTS; k++) pending_units[k] = 0;
         end
      end else begin
         pending_units[r] = it.amount;
         if (it.last) begin
            fits_all = 1'b1;
            for (k = 0; k < nr; k++) begin
               if (pending_units[k] > need_units[p][k] || pending_units[k] > avail_units[k])
                  fits_all = 1'b0;
            end
            if (!fits_all) begin
               res.status = ST_OVER;
            end else begin
               for (k = 0; k < nr; k++) begin
                  held_units[p][k] += pending_units[k];
                  avail_units[k]   -= pending_units[k];
                  need_units[p][k] -= pending_units[k];
               end
               // Safety check: sweep processes while any of them can finish
               for (k = 0; k < nr; k++) work_units[k] = avail_units[k];
               done = '0;
               progress = 1'b1;
               for (sweep = 0; sweep < np && progress; sweep++) begin
                  progress = 1'b0;
                  for (q = 0; q < np; q++) begin
                     if (!done[q]) begin
                        fits = 1'b1;
                        for (k = 0; k < nr; k++)
                           if (need_units[q][k] > work_units[k]) fits = 1'b0;
                        if (fits) begin
                           done[q] = 1'b1;
                           progress = 1'b1;
                           for (k = 0; k < nr; k++) work_units[k] += held_units[q][k];
                        end
                     end
                  end
               end
               res.finished_mask = done;
               if (done == MASK_W'((32'd1 << np) - 1)) begin
                  res.status = ST_GRANTED;
               end else begin
                  // Roll back the unsafe grant
                  res.status = ST_UNSAFE;
                  for (k = 0; k < nr; k++) begin
                     avail_units[k]   += pending_units[k];
                     held_units[p][k] -= pending_units[k];
                     need_units[p][k] += pending_units[k];
                  end
               end
            end
            for (k = 0; k < RES_SLOTS; k++) pending_units[k] = 0;
         end
      end
      return res;
   endfunction

   // Random count in 0..ceiling, with the ceiling itself drawn often
   function automatic logic [AMOUNT_W-1:0] pick_up_to(logic [31:0] ceiling);
      if (ceiling == 0) return '0;
      if ($urandom_range(0, 3) == 0) return AMOUNT_W'(ceiling);
      return AMOUNT_W'($urandom_range(0, ceiling));
   endfunction

   // Offer one item, hold it until the transfer, then record its result
   task automatic drive_item(input alloc_item_type it, input logic fixed,
                             input alloc_result_type fixed_res);
      alloc_result_type predicted;
      if (idle_on && $urandom_range(1, 100) <= idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= it.command;
      req_bus.process  <= it.proc_id;
      req_bus.resource <= it.resource;
      req_bus.amount   <= it.amount;
      req_bus.last     <= it.last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = allocator_outcome(it);
      awaited_results.push_back(fixed ? fixed_res : predicted);
      items_sent++;
   endtask

   // Drop valid and hold until every outstanding result has come back
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // Write both count registers back to back
   task automatic write_counts(input logic [CSR_DATA_W-1:0] res_val,
                               input logic [CSR_DATA_W-1:0] proc_val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_NUM_RESOURCES;
      csr_bus.data  <= res_val;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      res_in_use = res_val[NUM_RES_W-1:0];
      csr_bus.index <= CSR_NUM_PROCESSES;
      csr_bus.data  <= proc_val;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      proc_in_use = proc_val[NUM_PROC_W-1:0];
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly well-formed traffic: available counts, claims, multi-element
   // requests sized from the current need; some raw noise on top
   task automatic send_random_traffic(input int count);
      int               nr, np, p, r, steps, s, stop_at;
      logic [31:0]      ceiling;
      alloc_item_type   it;
      alloc_result_type none;
      nr = res_limit();
      np = proc_limit();
      none = '0;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0: begin
               it.command  = COMMAND_W'($urandom_range(0, 3));
               it.proc_id  = PROCESS_W'($urandom());
               it.resource = RESOURCE_W'($urandom());
               it.amount   = AMOUNT_W'($urandom());
               it.last     = 1'($urandom());
               drive_item(it, 1'b0, none);
            end
            1, 2: begin
               it.command  = CMD_SET_AVAIL;
               it.proc_id  = PROCESS_W'($urandom());
               it.resource = RESOURCE_W'($urandom_range(0, nr - 1));
               it.amount   = ($urandom_range(0, 7) == 0) ? AMOUNT_W'($urandom())
                                                         : AMOUNT_W'($urandom_range(0, 48));
               it.last     = 1'($urandom());
               drive_item(it, 1'b0, none);
            end
            3, 4: begin
               it.command  = CMD_SET_CLAIM;
               it.proc_id  = PROCESS_W'($urandom_range(0, np - 1));
               it.resource = RESOURCE_W'($urandom_range(0, nr - 1));
               ceiling = avail_units[it.resource];
               it.amount   = ($urandom_range(0, 9) == 0)
                             ? AMOUNT_W'(ceiling + $urandom_range(1, 8)) : pick_up_to(ceiling);
               it.last     = 1'($urandom());
               drive_item(it, 1'b0, none);
            end
            default: begin
               p = $urandom_range(0, np - 1);
               steps = $urandom_range(1, nr + 1);
               for (s = 0; s < steps; s++) begin
                  r = $urandom_range(0, nr - 1);
                  ceiling = (need_units[p][r] < avail_units[r]) ? need_units[p][r]
                                                                : avail_units[r];
                  it.command  = CMD_REQUEST;
                  it.resource = RESOURCE_W'(r);
                  it.last     = (s == steps - 1);
                  it.proc_id  = (it.last && $urandom_range(0, 7) == 0)
                                ? PROCESS_W'($urandom_range(0, np - 1)) : PROCESS_W'(p);
                  case ($urandom_range(0, 11))
                     0: it.amount = pick_up_to(claim_units[p][r]);
                     1: it.amount = AMOUNT_W'(claim_units[p][r] + 1);
                     default: it.amount = pick_up_to(ceiling);
                  endcase
                  drive_item(it, 1'b0, none);
               end
            end
         endcase
      end
   endtask

   // Stimulus and verdict
   initial begin
      int               i, k, phase;
      alloc_item_type   it;
      alloc_result_type fixed_res;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.command  = CMD_SET_AVAIL;
      req_bus.process  = '0;
      req_bus.resource = '0;
      req_bus.amount   = '0;
      req_bus.last     = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_NUM_RESOURCES;
      csr_bus.data     = '0;
      for (k = 0; k < RES_SLOTS; k++) begin
         avail_units[k]   = 0;
         pending_units[k] = 0;
         for (i = 0; i < PROC_SLOTS; i++) begin
            claim_units[i][k] = 0;
            held_units[i][k]  = 0;
            need_units[i][k]  = 0;
         end
      end
      res_in_use  = NUM_RES_RESET;
      proc_in_use = NUM_PROC_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         it.command              = DIRECTED_ROWS[i].command;
         it.proc_id              = DIRECTED_ROWS[i].proc_id;
         it.resource             = DIRECTED_ROWS[i].resource;
         it.amount               = DIRECTED_ROWS[i].amount;
         it.last                 = DIRECTED_ROWS[i].last;
         fixed_res.status        = DIRECTED_ROWS[i].status;
         fixed_res.finished_mask = DIRECTED_ROWS[i].finished_mask;
         drive_item(it, DIRECTED_ROWS[i].fixed, fixed_res);
      end
      wait_for_results();

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         // the closing phase runs at full rate on both sides
         if (phase == NUM_PHASES - 1) idle_on = 1'b0;
         write_counts(RES_SETTINGS[phase], PROC_SETTINGS[phase]);
         send_random_traffic(ITEMS_PER_PHASE);
         wait_for_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Result side ready, stalled in random bursts
   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(1, 100) <= idle_pct) begin
            stall = $urandom_range(0, 16);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Change the idling density now and then, quiet stretches included
   always @(posedge clock) begin
      pace_count <= pace_count + 1;
      if (pace_count % 150 == 0) begin
         case ($urandom_range(0, 2))
            0: idle_pct <= 0;
            1: idle_pct <= 6;
            default: idle_pct <= 25;
         endcase
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin : check_results
      alloc_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: status %0d mask %02h",
                        rsp_bus.status, rsp_bus.finished_mask);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_bus.status !== want.status ||
                rsp_bus.finished_mask !== want.finished_mask) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("result mismatch: status exp %0d got %0d, mask exp %02h got %02h",
                           want.status, rsp_bus.status, want.finished_mask,
                           rsp_bus.finished_mask);
            end
         end
      end
   end

   // Stop the run when no transfer happens for too long
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ----- sim.f -----
src/bsa_pkg.sv
src/bsa_if.sv
src/bsa_csr.sv
src/bsa_ctrl.sv
src/bsa_dpath.sv
src/banker_safety_allocator.sv
tb/banker_safety_allocator_tb.sv
